FILE: hw/rtl/fct_pkg.sv
// Package for the frustum cull test: sizes, action codes and pipeline control type.
`default_nettype none
package fct_pkg;
	localparam int NUM_PLANES = 6;
	localparam int FRAC_BITS  = 16;
	localparam int SLOT_COUNT = 4 * NUM_PLANES;
	localparam int PLANE_W    = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
	localparam int SUM_W      = 67;

	localparam logic [2:0] ACT_LOAD    = 3'd0;
	localparam logic [2:0] ACT_POINT   = 3'd1;
	localparam logic [2:0] ACT_SPHERE  = 3'd2;
	localparam logic [2:0] ACT_BOX_ANY = 3'd3;
	localparam logic [2:0] ACT_BOX_ALL = 3'd4;

	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last;
		logic [2:0] action;
	} fct_ctrl_t;
endpackage
`default_nettype wire

FILE: hw/rtl/fct_issue.sv
// Plane coefficient store and per-plane issue sequencer for one query at a time.
`default_nettype none
module fct_issue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         action,
	input  wire logic [4:0]         coef_slot,
	input  wire logic signed [31:0] coef_value,
	input  wire logic signed [31:0] x_lo,
	input  wire logic signed [31:0] y_lo,
	input  wire logic signed [31:0] z_lo,
	input  wire logic signed [31:0] x_hi,
	input  wire logic signed [31:0] y_hi,
	input  wire logic signed [31:0] z_hi,
	input  wire logic [30:0]        radius,
	output fct_pkg::fct_ctrl_t      beat,
	output logic signed [31:0]      xl,
	output logic signed [31:0]      yl,
	output logic signed [31:0]      zl,
	output logic signed [31:0]      xh,
	output logic signed [31:0]      yh,
	output logic signed [31:0]      zh,
	output logic [30:0]             rad,
	output logic signed [31:0]      ca,
	output logic signed [31:0]      cb,
	output logic signed [31:0]      cc,
	output logic signed [31:0]      cd
);
	logic signed [31:0] coef_q [fct_pkg::NUM_PLANES][4];
	logic                        busy_q;
	logic [fct_pkg::PLANE_W-1:0] plane_q;
	logic [2:0]                  act_q;
	logic                        accept;
	logic                        is_query;
	logic                        last_plane;
	logic                        slot_ok;

	assign in_stall   = busy_q;
	assign accept     = in_valid && !busy_q;
	assign is_query   = (action == fct_pkg::ACT_POINT) || (action == fct_pkg::ACT_SPHERE) ||
	                    (action == fct_pkg::ACT_BOX_ANY) || (action == fct_pkg::ACT_BOX_ALL);
	assign last_plane = (plane_q == fct_pkg::PLANE_W'(fct_pkg::NUM_PLANES - 1));
	assign slot_ok    = ({1'b0, coef_slot} < 6'(fct_pkg::SLOT_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			plane_q <= '0;
			for (int p = 0; p < fct_pkg::NUM_PLANES; p++) begin
				for (int k = 0; k < 4; k++) begin
					coef_q[p][k] <= '0;
				end
			end
		end else begin
			if (accept) begin
				if (action == fct_pkg::ACT_LOAD) begin
					if (slot_ok) begin
						coef_q[fct_pkg::PLANE_W'(coef_slot >> 2)][coef_slot[1:0]] <= coef_value;
					end
				end else if (is_query) begin
					busy_q  <= 1'b1;
					plane_q <= '0;
				end
			end else if (busy_q && en) begin
				if (last_plane) begin
					busy_q <= 1'b0;
				end
				plane_q <= plane_q + fct_pkg::PLANE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			act_q <= action;
			xl    <= x_lo;
			yl    <= y_lo;
			zl    <= z_lo;
			xh    <= x_hi;
			yh    <= y_hi;
			zh    <= z_hi;
			rad   <= radius;
		end
	end

	always_comb begin
		beat.valid  = busy_q;
		beat.first  = (plane_q == '0);
		beat.last   = last_plane;
		beat.action = act_q;
		ca = coef_q[plane_q][0];
		cb = coef_q[plane_q][1];
		cc = coef_q[plane_q][2];
		cd = coef_q[plane_q][3];
	end
endmodule
`default_nettype wire

FILE: hw/rtl/fct_datapath.sv
// Plane distance pipeline: products, partial sums, per-corner behind flags.
`default_nettype none
module fct_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire fct_pkg::fct_ctrl_t beat,
	input  wire logic signed [31:0] xl,
	input  wire logic signed [31:0] yl,
	input  wire logic signed [31:0] zl,
	input  wire logic signed [31:0] xh,
	input  wire logic signed [31:0] yh,
	input  wire logic signed [31:0] zh,
	input  wire logic [30:0]        rad,
	input  wire logic signed [31:0] ca,
	input  wire logic signed [31:0] cb,
	input  wire logic signed [31:0] cc,
	input  wire logic signed [31:0] cd,
	output fct_pkg::fct_ctrl_t      ctrl_s3,
	output logic [7:0]              behind_s3
);
	localparam int W = fct_pkg::SUM_W;

	fct_pkg::fct_ctrl_t  ctrl_s1, ctrl_s2;
	logic signed [63:0]  axl_s1, axh_s1, byl_s1, byh_s1, czl_s1, czh_s1;
	logic signed [W-1:0] dt_s1, bias_s1;
	logic signed [W-1:0] ab_s2 [4];
	logic signed [W-1:0] cz_s2 [2];
	logic signed [W-1:0] sum   [8];
	logic [7:0]          beh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else if (en) begin
			ctrl_s1 <= beat;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			axl_s1  <= ca * xl;
			axh_s1  <= ca * xh;
			byl_s1  <= cb * yl;
			byh_s1  <= cb * yh;
			czl_s1  <= cc * zl;
			czh_s1  <= cc * zh;
			dt_s1   <= W'(cd) <<< fct_pkg::FRAC_BITS;
			bias_s1 <= (beat.action == fct_pkg::ACT_SPHERE) ?
			           (W'({1'b0, rad}) <<< fct_pkg::FRAC_BITS) : '0;
			ab_s2[0] <= W'(axl_s1) + W'(byl_s1);
			ab_s2[1] <= W'(axh_s1) + W'(byl_s1);
			ab_s2[2] <= W'(axl_s1) + W'(byh_s1);
			ab_s2[3] <= W'(axh_s1) + W'(byh_s1);
			cz_s2[0] <= W'(czl_s1) + dt_s1 + bias_s1;
			cz_s2[1] <= W'(czh_s1) + dt_s1 + bias_s1;
			behind_s3 <= beh;
		end
	end

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			sum[k] = ab_s2[k % 4] + cz_s2[k / 4];
			beh[k] = sum[k][W-1] || (sum[k] == '0);
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/frustum_cull_test.sv
// Top level of the frustum cull test: issue, distance pipeline, per-query reduction.
//
//   channel  signals                               direction  meaning
//   input    in_valid/in_stall + item fields       in         load or query transaction
//   result   res_valid/res_stall + inside_res      out        one flag per query
//
// An accepted query issues one plane per cycle while the result is not stalled, NUM_PLANES
// planes in all (a plane row read and six multiplies each), starting the cycle after
// acceptance; the next item is taken the cycle after the last plane issues.
// The result registers in res_valid_q after the last issue passes stages s1, s2 and s3.
// Loads give no result. Reset clears the plane store and all valid bits.
// A stalled result freezes issue and the whole pipeline; loads and one query are still taken.
`default_nettype none
module frustum_cull_test (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         action,
	input  wire logic [4:0]         coef_slot,
	input  wire logic signed [31:0] coef_value,
	input  wire logic signed [31:0] x_lo,
	input  wire logic signed [31:0] y_lo,
	input  wire logic signed [31:0] z_lo,
	input  wire logic signed [31:0] x_hi,
	input  wire logic signed [31:0] y_hi,
	input  wire logic signed [31:0] z_hi,
	input  wire logic [30:0]        radius,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic                    inside_res
);
	fct_pkg::fct_ctrl_t beat, ctrl_s3;
	logic signed [31:0] xl, yl, zl, xh, yh, zh, ca, cb, cc, cd;
	logic [30:0]        rad;
	logic [7:0]         behind_s3;
	logic               en, res_valid_q, inside_q, acc_q, out_here, acc_next;

	assign en         = !(res_valid_q && res_stall);
	assign res_valid  = res_valid_q;
	assign inside_res = inside_q;

	fct_issue u_issue (
		.clk, .arst_n, .en, .in_valid, .in_stall, .action, .coef_slot, .coef_value,
		.x_lo, .y_lo, .z_lo, .x_hi, .y_hi, .z_hi, .radius,
		.beat, .xl, .yl, .zl, .xh, .yh, .zh, .rad, .ca, .cb, .cc, .cd
	);

	fct_datapath u_dp (
		.clk, .arst_n, .en, .beat, .xl, .yl, .zl, .xh, .yh, .zh, .rad,
		.ca, .cb, .cc, .cd, .ctrl_s3, .behind_s3
	);

	always_comb begin
		unique case (ctrl_s3.action)
			fct_pkg::ACT_BOX_ANY: out_here = &behind_s3;
			fct_pkg::ACT_BOX_ALL: out_here = |behind_s3;
			default:              out_here = behind_s3[0];
		endcase
		acc_next = (ctrl_s3.first ? 1'b1 : acc_q) && !out_here;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= ctrl_s3.valid && ctrl_s3.last;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctrl_s3.valid) begin
			acc_q <= acc_next;
			if (ctrl_s3.last) begin
				inside_q <= acc_next;
			end
		end
	end

	a_res_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(en && ctrl_s3.valid && ctrl_s3.last) |=> res_valid)
		else $error("result missing after last plane");
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(inside_res) && $stable(ctrl_s3)))
		else $error("pipeline moved under result stall");
	a_busy_after_query: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && action != fct_pkg::ACT_LOAD && action <= fct_pkg::ACT_BOX_ALL)
		|=> in_stall)
		else $error("query accepted without issue busy");
endmodule
`default_nettype wire
